@@ design/spblc_pkg.sv @@
// ----------------------------------------------------------------------------
// Soft-power latch controller package
// Shared types, register indexes, cause codes and reset values.
// ----------------------------------------------------------------------------
package spblc_pkg;

    // Timestamp arithmetic width: differences wrap modulo 2^TIME_BITS.
    localparam int TIME_BITS = 32;
    localparam int NOW_BITS  = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [TIME_BITS-1:0] t_time;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TIME     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHECK_PERIOD  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_BATTERY   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_LATCHED = 3'd4;

    // Shutdown cause codes
    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_BUTTON  = 2'd1;
    localparam logic [1:0] CAUSE_BATTERY = 2'd2;

    // Register reset values
    localparam logic [15:0] RST_HOLD_TIME    = 16'd2000;
    localparam logic [15:0] RST_CHECK_PERIOD = 16'd10000;
    localparam logic [15:0] RST_LOW_BATTERY  = 16'd3200;
    localparam logic [3:0]  RST_LOW_LIMIT    = 4'd3;

    localparam logic [3:0]  LOW_COUNT_MAX    = 4'hF;

    typedef struct packed {
        logic [15:0] hold_time_ms;
        logic [15:0] check_period_ms;
        logic [15:0] low_battery_mv;
        logic [3:0]  low_check_limit;
        logic        start_latched;
    } t_cfg;

    // Write strobe for the boot latch level, which also loads the latch
    typedef struct packed {
        logic wr;
        logic value;
    } t_latch_wr;

    typedef struct packed {
        logic        latched;
        logic        release_seen;
        logic        shutdown_done;
        t_time       press_start_ms;
        t_time       last_check_ms;
        logic [3:0]  low_count;
    } t_state;

    typedef struct packed {
        logic [NOW_BITS-1:0] now_ms;
        logic                button_pressed;
        logic                battery_present;
        logic                usb_present;
        logic [15:0]         battery_mv;
    } t_item;

    typedef struct packed {
        logic       latch_on;
        logic       latched_now;
        logic       shutdown_now;
        logic [1:0] shutdown_cause;
    } t_result;

endpackage

@@ design/spblc_cfg.sv @@
// ----------------------------------------------------------------------------
// Soft-power latch controller configuration registers
// Holds the five control registers and flags writes of the boot latch level.
// ----------------------------------------------------------------------------
module spblc_cfg
    import spblc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr,
    input  logic [CFG_IDX_BITS-1:0]  i_index,
    input  logic [CFG_DATA_BITS-1:0] i_data,
    output t_cfg                     o_cfg,
    output t_latch_wr                o_latch_wr
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_time_ms    <= RST_HOLD_TIME;
            r_cfg.check_period_ms <= RST_CHECK_PERIOD;
            r_cfg.low_battery_mv  <= RST_LOW_BATTERY;
            r_cfg.low_check_limit <= RST_LOW_LIMIT;
            r_cfg.start_latched   <= 1'b0;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_HOLD_TIME:     r_cfg.hold_time_ms    <= i_data;
                CFG_CHECK_PERIOD:  r_cfg.check_period_ms <= i_data;
                CFG_LOW_BATTERY:   r_cfg.low_battery_mv  <= i_data;
                CFG_LOW_LIMIT:     r_cfg.low_check_limit <= i_data[3:0];
                CFG_START_LATCHED: r_cfg.start_latched   <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg            = r_cfg;
    assign o_latch_wr.wr    = i_wr && (i_index == CFG_START_LATCHED);
    assign o_latch_wr.value = i_data[0];

endmodule

@@ design/spblc_step.sv @@
// ----------------------------------------------------------------------------
// Soft-power latch controller tick logic
// Computes the next controller state and the result for one poll tick.
// ----------------------------------------------------------------------------
module spblc_step
    import spblc_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    always_comb begin
        t_state      s;
        t_result     res;
        t_time       now;
        t_time       press_diff;
        t_time       check_diff;
        logic        batt_low;
        logic [3:0]  cnt;

        s          = i_state;
        res        = '0;
        now        = t_time'(i_item.now_ms);
        press_diff = now - i_state.press_start_ms;
        check_diff = now - i_state.last_check_ms;
        batt_low   = i_item.battery_present && !i_item.usb_present &&
                     (i_item.battery_mv != 16'd0) &&
                     (i_item.battery_mv < i_cfg.low_battery_mv);
        cnt        = (i_state.low_count != LOW_COUNT_MAX) ?
                     i_state.low_count + 4'd1 : i_state.low_count;

        // Button: a zero start time means no press is being timed
        if (!s.shutdown_done) begin
            if (i_item.button_pressed) begin
                if (i_state.press_start_ms == '0) begin
                    s.press_start_ms = now;
                end else if (press_diff >= t_time'(i_cfg.hold_time_ms)) begin
                    if (!i_state.latched) begin
                        s.latched       = 1'b1;
                        s.release_seen  = 1'b0;
                        res.latched_now = 1'b1;
                    end else if (i_state.release_seen) begin
                        s.shutdown_done    = 1'b1;
                        s.latched          = 1'b0;
                        res.shutdown_now   = 1'b1;
                        res.shutdown_cause = CAUSE_BUTTON;
                    end
                    s.press_start_ms = '0;
                end
            end else begin
                s.release_seen   = 1'b1;
                s.press_start_ms = '0;
            end
        end

        // Battery check, skipped once the unit has shut down
        if (!s.shutdown_done && (check_diff >= t_time'(i_cfg.check_period_ms))) begin
            s.last_check_ms = now;
            if (batt_low) begin
                s.low_count = cnt;
                if (cnt >= i_cfg.low_check_limit) begin
                    s.shutdown_done    = 1'b1;
                    s.latched          = 1'b0;
                    res.shutdown_now   = 1'b1;
                    res.shutdown_cause = CAUSE_BATTERY;
                end
            end else begin
                s.low_count = 4'd0;
            end
        end

        res.latch_on = s.latched;
        o_state      = s;
        o_result     = res;
    end

endmodule

@@ design/soft_power_button_latch_controller_unit.sv @@
// ----------------------------------------------------------------------------
// Soft-power button latch controller
// Times button holds to latch power on or request shutdown, and cuts power
// after repeated low battery checks. One result per poll tick.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+----------------------------------
//  in       | i_in_valid / o_in_stall     | now_ms, button, battery, usb, mV
//  out      | o_out_valid / i_out_stall   | latch_on, latched_now, shutdown
//  cfg      | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  Pipeline: two-stage path, input register then result register; a tick's
//  result is registered when it moves on from the input register, and one
//  tick is taken per cycle as long as the output side keeps draining.
//  State updates in the cycle a tick moves from the input register to the
//  result register, so ticks see the effects of all earlier ticks.
//  Reset (synchronous, active low) loads register defaults and clears state.
//  An output stall holds the result register and, once the input register
//  is full as well, raises o_in_stall. Configuration writes never stall.
// ----------------------------------------------------------------------------
module soft_power_button_latch_controller_unit
    import spblc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // tick input
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [NOW_BITS-1:0]      i_now_ms,
    input  logic                     i_button_pressed,
    input  logic                     i_battery_present,
    input  logic                     i_usb_present,
    input  logic [15:0]              i_battery_mv,
    // result output
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_latch_on,
    output logic                     o_latched_now,
    output logic                     o_shutdown_now,
    output logic [1:0]               o_shutdown_cause,
    // configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_latch_wr latch_wr;

    logic    r_in_valid;
    t_item   r_in_item;
    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    t_result r_out_res;
    t_result n_out_res;

    logic    out_free;
    logic    advance;
    logic    in_take;

    // Registers always accept writes; software must write only while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    spblc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (i_cfg_valid),
        .i_index    (i_cfg_index),
        .i_data     (i_cfg_data),
        .o_cfg      (cfg),
        .o_latch_wr (latch_wr)
    );

    // Result register is free when empty or being drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    // Input register frees up when empty or when its tick advances
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    spblc_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out_res)
    );

    // Control state and valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // Load the boot level into the latch unless already shut down or a tick advances
            if (advance) begin
                r_state <= n_state;
            end else if (latch_wr.wr && !r_state.shutdown_done) begin
                r_state.latched <= latch_wr.value;
            end
        end
    end

    // Payload registers: capture on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.now_ms          <= i_now_ms;
            r_in_item.button_pressed  <= i_button_pressed;
            r_in_item.battery_present <= i_battery_present;
            r_in_item.usb_present     <= i_usb_present;
            r_in_item.battery_mv      <= i_battery_mv;
        end
        if (advance) begin
            r_out_res <= n_out_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_latch_on       = r_out_res.latch_on;
    assign o_latched_now    = r_out_res.latched_now;
    assign o_shutdown_now   = r_out_res.shutdown_now;
    assign o_shutdown_cause = r_out_res.shutdown_cause;

endmodule

@@ design/spblc_checker.sv @@
// ----------------------------------------------------------------------------
// Soft-power latch controller port checker
// Watches the top-level ports for result consistency and handshake rules.
// ----------------------------------------------------------------------------
module spblc_checker
    import spblc_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic                     o_latch_on,
    input logic                     o_latched_now,
    input logic                     o_shutdown_now,
    input logic [1:0]               o_shutdown_cause
);

    // A shutdown result drops the latch and names a real cause
    a_shutdown_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_shutdown_now) |->
            (!o_latch_on && (o_shutdown_cause == CAUSE_BUTTON ||
                             o_shutdown_cause == CAUSE_BATTERY)))
        else $error("shutdown result with latch on or no cause");

    // Without a shutdown the cause stays at none
    a_cause_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_shutdown_now) |-> (o_shutdown_cause == CAUSE_NONE))
        else $error("cause set without shutdown");

    // Latching on leaves the latch high, unless the battery check of the
    // same tick cuts power right away
    a_latch_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_latched_now) |->
            ((o_latch_on && !o_shutdown_now) ||
             (!o_latch_on && o_shutdown_now && o_shutdown_cause == CAUSE_BATTERY)))
        else $error("latched_now inconsistent with latch level");

    // Shutdown happens once: the next result cannot shut down again
    a_single_shutdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_shutdown_now) |=>
            !(o_out_valid && o_shutdown_now))
        else $error("second shutdown pulse");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_latch_on) && $stable(o_latched_now) &&
             $stable(o_shutdown_now) && $stable(o_shutdown_cause)))
        else $error("stalled result changed");

endmodule

bind soft_power_button_latch_controller_unit spblc_checker u_spblc_checker (.*);

@@ bench/soft_power_button_latch_controller_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Soft-power latch controller testbench
// Drives poll ticks through the valid/stall input channel, mirrors the latch,
// release, press-timer and low-battery logic in a behavioral model, and checks
// every result transfer field by field. The shutdown path ends the block's
// useful life until reset, so it is exercised once, at the very end; every
// tick sent before that is trimmed so that it cannot shut the block down.
// ----------------------------------------------------------------------------
module soft_power_button_latch_controller_unit_tb;
    import spblc_pkg::*;

    localparam int CYCLE_LIMIT    = 100000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int IDLE_PERCENT   = 16;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 100;

    // Clock, reset and every block input start at a known level.
    logic                     i_clk             = 1'b0;
    logic                     i_rst_n           = 1'b0;
    logic                     i_in_valid        = 1'b0;
    logic [NOW_BITS-1:0]      i_now_ms          = '0;
    logic                     i_button_pressed  = 1'b0;
    logic                     i_battery_present = 1'b0;
    logic                     i_usb_present     = 1'b0;
    logic [15:0]              i_battery_mv      = '0;
    logic                     i_out_stall       = 1'b0;
    logic                     i_cfg_valid       = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index       = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data        = '0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic                     o_latch_on;
    logic                     o_latched_now;
    logic                     o_shutdown_now;
    logic [1:0]               o_shutdown_cause;
    logic                     o_cfg_ready;

    // Behavioral copy of the controller: register file and live state.
    t_cfg    latch_cfg;
    t_state  latch_state;
    t_result pending_results[$];

    int unsigned mismatch_count = 0;
    int unsigned result_count   = 0;
    int unsigned cycle_count    = 0;

    // Traffic shaping knobs, flipped by the test tasks.
    logic tx_steady      = 1'b0;
    logic rx_steady      = 1'b0;
    logic allow_shutdown = 1'b0;
    logic rx_hold_req    = 1'b0;
    logic rx_hold_ack    = 1'b0;
    int unsigned rx_hold_left = 0;

    // Stimulus generator state: a running millisecond clock and button runs.
    t_time       clock_ms = '0;
    logic        btn_level = 1'b0;
    int unsigned btn_run = 0;

    soft_power_button_latch_controller_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_now_ms         (i_now_ms),
        .i_button_pressed (i_button_pressed),
        .i_battery_present(i_battery_present),
        .i_usb_present    (i_usb_present),
        .i_battery_mv     (i_battery_mv),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_latch_on       (o_latch_on),
        .o_latched_now    (o_latched_now),
        .o_shutdown_now   (o_shutdown_now),
        .o_shutdown_cause (o_shutdown_cause),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a correct run finishes far below this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("soft_power_button_latch_controller_unit_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Controller model
    // ------------------------------------------------------------------------

    // Advance the model by one poll tick and return the result it produces.
    function automatic t_result advance_latch_model(input t_item it);
        t_result res;
        t_time   held;
        t_time   since_check;
        logic    low_reading;
        res         = '0;
        held        = t_time'(it.now_ms) - latch_state.press_start_ms;
        since_check = t_time'(it.now_ms) - latch_state.last_check_ms;

        if (!latch_state.shutdown_done) begin
            if (it.button_pressed) begin
                // A zero start time means no press is being timed, so a press
                // that begins at timestamp zero is only timed from the next tick.
                if (latch_state.press_start_ms == '0) begin
                    latch_state.press_start_ms = it.now_ms;
                end else if (held >= t_time'(latch_cfg.hold_time_ms)) begin
                    if (!latch_state.latched) begin
                        latch_state.latched      = 1'b1;
                        latch_state.release_seen = 1'b0;
                        res.latched_now          = 1'b1;
                    end else if (latch_state.release_seen) begin
                        latch_state.shutdown_done = 1'b1;
                        latch_state.latched       = 1'b0;
                        res.shutdown_now          = 1'b1;
                        res.shutdown_cause        = CAUSE_BUTTON;
                    end
                    // Latched with no release yet: only the timer is cleared.
                    latch_state.press_start_ms = '0;
                end
            end else begin
                latch_state.release_seen   = 1'b1;
                latch_state.press_start_ms = '0;
            end
        end

        if (!latch_state.shutdown_done && since_check >= t_time'(latch_cfg.check_period_ms)) begin
            latch_state.last_check_ms = it.now_ms;
            low_reading = it.battery_present && !it.usb_present && it.battery_mv != '0
                          && it.battery_mv < latch_cfg.low_battery_mv;
            if (low_reading) begin
                // Saturate the count; any limit, zero included, is compared after.
                if (latch_state.low_count < LOW_COUNT_MAX)
                    latch_state.low_count = latch_state.low_count + 1'b1;
                if (latch_state.low_count >= latch_cfg.low_check_limit) begin
                    latch_state.shutdown_done = 1'b1;
                    latch_state.latched       = 1'b0;
                    res.shutdown_now          = 1'b1;
                    res.shutdown_cause        = CAUSE_BATTERY;
                end
            end else begin
                latch_state.low_count = '0;
            end
        end

        res.latch_on = latch_state.latched;
        return res;
    endfunction

    // Mirror a register write; unknown indexes are dropped, data is masked.
    function automatic void apply_reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                                            input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_HOLD_TIME:    latch_cfg.hold_time_ms    = data;
            CFG_CHECK_PERIOD: latch_cfg.check_period_ms = data;
            CFG_LOW_BATTERY:  latch_cfg.low_battery_mv  = data;
            CFG_LOW_LIMIT:    latch_cfg.low_check_limit = data[3:0];
            CFG_START_LATCHED: begin
                latch_cfg.start_latched = data[0];
                if (!latch_state.shutdown_done)
                    latch_state.latched = data[0];
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Send one poll tick and queue its expected result at the transfer.
    task automatic send_tick(input t_item tick);
        t_state  saved;
        t_result trial;
        // Until the final test, steer clear of shutdown: a released button
        // cannot power off, and USB power cannot count as a low reading.
        if (!allow_shutdown) begin
            saved = latch_state;
            trial = advance_latch_model(tick);
            latch_state = saved;
            if (trial.shutdown_now) begin
                tick.button_pressed = 1'b0;
                trial = advance_latch_model(tick);
                latch_state = saved;
                if (trial.shutdown_now)
                    tick.usb_present = 1'b1;
            end
        end
        if (!tx_steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            repeat ($urandom_range(1, 3)) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                i_now_ms   = $urandom;
            end
        end
        @(negedge i_clk);
        i_in_valid        = 1'b1;
        i_now_ms          = tick.now_ms;
        i_button_pressed  = tick.button_pressed;
        i_battery_present = tick.battery_present;
        i_usb_present     = tick.usb_present;
        i_battery_mv      = tick.battery_mv;
        // Hold the payload until the block takes it.
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(advance_latch_model(tick));
    endtask

    task automatic send_fields(input t_time now, input logic btn, input logic batt,
                               input logic usb, input logic [15:0] mv);
        t_item tick;
        tick.now_ms          = now;
        tick.button_pressed  = btn;
        tick.battery_present = batt;
        tick.usb_present     = usb;
        tick.battery_mv      = mv;
        send_tick(tick);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg_write(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drop valid and wait until every queued result has been transferred.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random tick: a running clock with occasional jumps, button held and
    // released in runs, battery readings clustered around the threshold.
    function automatic t_item next_random_tick();
        t_item       tick;
        int unsigned step_cap;
        if ($urandom_range(0, 99) < 3) begin
            clock_ms = $urandom;
        end else begin
            step_cap = ($urandom_range(0, 1) != 0) ? latch_cfg.hold_time_ms
                                                   : latch_cfg.check_period_ms;
            clock_ms = clock_ms + $urandom_range(0, step_cap / 2 + 1);
        end
        if (btn_run == 0) begin
            btn_level = ~btn_level;
            btn_run   = $urandom_range(1, 8);
        end
        btn_run = btn_run - 1;
        tick.now_ms          = clock_ms;
        tick.button_pressed  = ($urandom_range(0, 99) < 8) ? ~btn_level : btn_level;
        tick.battery_present = ($urandom_range(0, 99) < 85);
        tick.usb_present     = ($urandom_range(0, 99) < 20);
        case ($urandom_range(0, 5))
            0:       tick.battery_mv = '0;
            1:       tick.battery_mv = 16'($urandom);
            default: tick.battery_mv = latch_cfg.low_battery_mv
                                       + 16'($urandom_range(0, 40)) - 16'd30;
        endcase
        return tick;
    endfunction

    task automatic write_all_regs(input logic [15:0] hold, input logic [15:0] period,
                                  input logic [15:0] low_mv, input logic [3:0] limit,
                                  input logic latch_level);
        write_reg(CFG_HOLD_TIME, hold);
        write_reg(CFG_CHECK_PERIOD, period);
        write_reg(CFG_LOW_BATTERY, low_mv);
        // Upper data bits are junk that the block must mask off.
        write_reg(CFG_LOW_LIMIT, {12'($urandom), limit});
        write_reg(CFG_START_LATCHED, {15'($urandom), latch_level});
    endtask

    // ------------------------------------------------------------------------
    // Receive side
    // ------------------------------------------------------------------------

    // Output stall: a long hold when a test asks for one, else none while steady, else random.
    always @(negedge i_clk) begin
        if (rx_hold_req != rx_hold_ack) begin
            rx_hold_ack  = rx_hold_req;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left != 0) begin
            i_out_stall  = 1'b1;
            rx_hold_left = rx_hold_left - 1;
        end else if (rx_steady) begin
            i_out_stall = 1'b0;
        end else begin
            i_out_stall = ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        // Keep the log bounded if the block goes badly wrong.
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH result %0d: %s", result_count, what);
    endtask

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (o_latch_on !== want.latch_on)
                    report_mismatch($sformatf("latch_on %b, want %b",
                                              o_latch_on, want.latch_on));
                if (o_latched_now !== want.latched_now)
                    report_mismatch($sformatf("latched_now %b, want %b",
                                              o_latched_now, want.latched_now));
                if (o_shutdown_now !== want.shutdown_now)
                    report_mismatch($sformatf("shutdown_now %b, want %b",
                                              o_shutdown_now, want.shutdown_now));
                if (o_shutdown_cause !== want.shutdown_cause)
                    report_mismatch($sformatf("shutdown_cause %0d, want %0d",
                                              o_shutdown_cause, want.shutdown_cause));
            end
            result_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Hand-built ticks at the reset settings: hold 2000, period 10000,
    // threshold 3200, limit 3.
    task automatic test_directed_ticks();
        // Press at timestamp zero is not timed.
        send_fields(32'd0, 1'b1, 1'b0, 1'b0, 16'd0);
        // Press timed across the wrap of the timestamp, then latch on.
        send_fields(32'hFFFF_FC00, 1'b1, 1'b1, 1'b0, 16'd3000);
        send_fields(32'h0000_0400, 1'b1, 1'b1, 1'b0, 16'd3000);
        // Full hold while latched with no release: timer clears only.
        send_fields(32'h0000_0800, 1'b1, 1'b0, 1'b0, 16'd0);
        send_fields(32'h0000_1000, 1'b1, 1'b0, 1'b0, 16'd0);
        send_fields(32'h0000_1100, 1'b0, 1'b0, 1'b0, 16'd0);
        send_fields(32'h0000_2000, 1'b1, 1'b0, 1'b0, 16'd0);
        send_fields(32'h0000_2010, 1'b0, 1'b0, 1'b0, 16'd0);
        // Battery checks: low, too early, unknown, USB, absent, at threshold.
        send_fields(32'd9000,  1'b0, 1'b1, 1'b0, 16'd3199);
        send_fields(32'd15000, 1'b0, 1'b1, 1'b0, 16'd3199);
        send_fields(32'd19000, 1'b0, 1'b1, 1'b0, 16'd0);
        send_fields(32'd29000, 1'b0, 1'b1, 1'b1, 16'd3199);
        send_fields(32'd39000, 1'b0, 1'b0, 1'b0, 16'd100);
        send_fields(32'd49000, 1'b0, 1'b1, 1'b0, 16'd3200);
        send_fields(32'd59000, 1'b0, 1'b1, 1'b0, 16'd1);
        send_fields(32'd69000, 1'b0, 1'b1, 1'b0, 16'hFFFF);
        send_fields(32'd79000, 1'b0, 1'b1, 1'b0, 16'd3199);
        send_fields(32'd89000, 1'b0, 1'b1, 1'b0, 16'd3199);
        send_fields(32'd99000, 1'b0, 1'b1, 1'b0, 16'd3199);
        // Timestamp at its maximum, then wrapped.
        send_fields(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 16'd3199);
        send_fields(32'h0000_2000, 1'b1, 1'b1, 1'b0, 16'hFFFF);
        clock_ms = 32'h0000_2000;
    endtask

    // Masked data, unused indexes and a live latch load.
    task automatic test_register_writes();
        wait_drained();
        write_reg(CFG_HOLD_TIME, 16'd300);
        write_reg(CFG_CHECK_PERIOD, 16'd700);
        write_reg(CFG_LOW_BATTERY, 16'd3600);
        write_reg(CFG_LOW_LIMIT, 16'hFFF2);
        write_reg(CFG_START_LATCHED, 16'hFFFE);
        for (int i = CFG_START_LATCHED + 1; i < (1 << CFG_IDX_BITS); i++)
            write_reg(CFG_IDX_BITS'(i), 16'hFFFF);
        send_tick(next_random_tick());
        wait_drained();
        write_reg(CFG_START_LATCHED, 16'h0001);
        repeat (12) send_tick(next_random_tick());
    endtask

    // Zero hold and zero period compare as always elapsed.
    task automatic test_zero_settings();
        wait_drained();
        write_all_regs(16'd0, 16'd0, 16'hFFFF, 4'd15, 1'b0);
        repeat (20) send_tick(next_random_tick());
    endtask

    // Stall the output for a long stretch while ticks keep coming, so the
    // block fills and stalls its input; then pause until it drains.
    task automatic test_backpressure();
        wait_drained();
        write_all_regs(16'd20, 16'd50, 16'd3300, 4'd4, 1'b0);
        tx_steady   = 1'b1;
        rx_hold_req = ~rx_hold_req;
        repeat (40) send_tick(next_random_tick());
        tx_steady = 1'b0;
        wait_drained();
    endtask

    // Phases of random ticks, each under its own register settings.
    task automatic test_random_phases();
        logic [15:0] hold;
        logic [15:0] period;
        logic [15:0] low_mv;
        for (int phase = 0; phase < 10; phase++) begin
            wait_drained();
            hold   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3000));
            period = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 5000));
            low_mv = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(2000, 4000));
            case (phase)
                0: write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 1'b1);
                1: write_all_regs(16'd1, 16'd1, 16'd0, 4'd1, 1'b0);
                2: write_all_regs(RST_HOLD_TIME, RST_CHECK_PERIOD, RST_LOW_BATTERY,
                                  RST_LOW_LIMIT, 1'b0);
                default: write_all_regs(hold, period, low_mv, 4'($urandom_range(0, 15)),
                                        1'($urandom));
            endcase
            // One phase runs with neither side idling.
            tx_steady = (phase == 5);
            rx_steady = (phase == 5);
            repeat (55) send_tick(next_random_tick());
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // One shutdown per run, on a path picked at random: a second button
    // hold, the zero count limit, or a run of low battery checks. After it
    // every tick is ignored and a boot latch write no longer loads the latch.
    task automatic test_shutdown();
        int unsigned path;
        int          n;
        t_item       tick;
        path = $urandom_range(0, 2);
        wait_drained();
        allow_shutdown = 1'b1;
        if (path == 0) begin
            write_reg(CFG_HOLD_TIME, 16'd10);
            write_reg(CFG_START_LATCHED, 16'd1);
        end else begin
            write_reg(CFG_CHECK_PERIOD, 16'd100);
            write_reg(CFG_LOW_BATTERY, 16'hFFFF);
            write_reg(CFG_LOW_LIMIT, (path == 1) ? 16'd0 : 16'($urandom_range(1, 15)));
        end
        n = 0;
        while (!latch_state.shutdown_done && n < 40) begin
            clock_ms = clock_ms + 100;
            if (clock_ms == '0)
                clock_ms = 1;
            tick.now_ms          = clock_ms;
            tick.button_pressed  = (path == 0) && (n != 0);
            tick.battery_present = (path != 0);
            tick.usb_present     = 1'b0;
            tick.battery_mv      = 16'($urandom_range(1, 65534));
            send_tick(tick);
            n++;
        end
        repeat (10) send_tick(next_random_tick());
        wait_drained();
        write_reg(CFG_START_LATCHED, 16'd1);
        repeat (5) send_tick(next_random_tick());
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------
    initial begin
        latch_cfg.hold_time_ms    = RST_HOLD_TIME;
        latch_cfg.check_period_ms = RST_CHECK_PERIOD;
        latch_cfg.low_battery_mv  = RST_LOW_BATTERY;
        latch_cfg.low_check_limit = RST_LOW_LIMIT;
        latch_cfg.start_latched   = 1'b0;
        latch_state               = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_ticks();
        test_register_writes();
        test_zero_settings();
        test_backpressure();
        test_random_phases();
        test_shutdown();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("soft_power_button_latch_controller_unit_tb OK");
        end else begin
            $display("soft_power_button_latch_controller_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ soft_power_button_latch_controller_unit.f @@
design/spblc_pkg.sv
design/spblc_cfg.sv
design/spblc_step.sv
design/soft_power_button_latch_controller_unit.sv
design/spblc_checker.sv
bench/soft_power_button_latch_controller_unit_tb.sv
